// File: hdl/bbde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbde_pkg
// Shared constants and field layout of the button bank debounce block.
// ----------------------------------------------------------------------------
package bbde_pkg;

	localparam int BUTTONS           = 12;
	localparam int BUTTONS_PER_GROUP = 4;
	localparam int IDX_W             = $clog2(BUTTONS);

	localparam int DEB_W  = 10;
	localparam int SNAP_W = 16;
	localparam int SEQ_W  = 32;
	localparam int CHAN_W = 2;
	localparam int BNUM_W = 3;

	localparam logic [DEB_W-1:0]  DEB_MAX  = '1;
	localparam logic [SNAP_W-1:0] SNAP_MAX = '1;

	localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(35);
	localparam logic [SNAP_W-1:0] SNAP_RESET = SNAP_W'(1000);

	localparam int IN_W  = 16;
	localparam int OUT_W = 40;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_SNAPSHOT = 2'd1,
		REG_SEQSTART = 2'd2
	} reg_index_t;

endpackage
`default_nettype wire

// File: hdl/button_bank_debounce_events.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_bank_debounce_events
// Debounces a bank of buttons and streams numbered change and snapshot events.
//
// s_axis carries one tick: raw_levels (active low, bit i = button i) and
// link_up. At the transfer the debounce state is updated in the same cycle and
// the results of the tick are queued in a job register. m_axis then carries
// the results one per cycle: an optional snapshot on a link rising edge (old
// states), change events in button order, an optional periodic snapshot (new
// states). tlast marks the final result of a tick; ticks with no result send
// nothing.
// The job register and then the single output register lie between a tick
// transfer and its first result. Throughput: one result per cycle while the
// receiver takes them; a tick has 1 to 24 results or none. s_tready rises
// again in the cycle the last result of the previous tick is loaded.
// When the receiver stalls, the output register holds and the job waits.
// cfg writes (index 0 debounce, 1 snapshot interval, 2 sequence start) are
// always ready. Reset releases all buttons, clears the timers and the link
// history, loads register defaults and sets the sequence counter to zero.
// ----------------------------------------------------------------------------
module button_bank_debounce_events
	import bbde_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [SEQ_W-1:0] cfg_data,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// [11:0] raw_levels, [12] link_up, [15:13] zero
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// [1:0] channel, [4:2] button_number, [5] is_pressed,
	// [37:6] sequence_number, [39:38] zero
	output logic [OUT_W-1:0]      m_tdata,
	// [0] from_snapshot
	output logic                  m_tuser,
	output logic                  m_tlast
);

	logic [DEB_W-1:0]  debounce_q;
	logic [SNAP_W-1:0] snap_int_q;
	logic [SEQ_W-1:0]  seq_q;

	logic [BUTTONS-1:0] state_q;
	logic [DEB_W-1:0]   acc_cnt_q [BUTTONS];
	logic [SNAP_W-1:0]  snap_cnt_q;
	logic               link_was_q;

	logic               pre_q;
	logic               post_q;
	logic [BUTTONS-1:0] ev_mask_q;
	logic [BUTTONS-1:0] old_st_q;
	logic [BUTTONS-1:0] new_st_q;
	logic [IDX_W-1:0]   idx_q;
	logic               busy;

	logic                 in_fire;
	logic [BUTTONS-1:0]   raw_pressed;
	logic                 link_in;
	logic [DEB_W-1:0]     acc_inc [BUTTONS];
	logic [BUTTONS-1:0]   change;
	logic [BUTTONS-1:0]   next_st;
	logic [SNAP_W-1:0]    snap_inc;
	logic [SNAP_W-1:0]    interval;
	logic                 rise;
	logic                 post_snap;
	logic [BUTTONS-1:0]   ev_mask;

	logic                 step;
	logic                 last_item;
	logic [IDX_W-1:0]     ev_idx;
	logic [BUTTONS-1:0]   ev_rest;
	logic [IDX_W-1:0]     emit_idx;
	logic                 emit_st;
	logic                 emit_snap;
	logic [CHAN_W-1:0]    emit_chan;
	logic [BNUM_W-1:0]    emit_bnum;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTONS - 1);

	assign cfg_ready   = 1'b1;
	assign raw_pressed = ~s_tdata[BUTTONS-1:0];
	assign link_in     = s_tdata[BUTTONS];
	assign in_fire     = s_tvalid && s_tready;

	always_comb begin
		for (int i = 0; i < BUTTONS; i++) begin
			acc_inc[i] = (acc_cnt_q[i] == DEB_MAX) ? acc_cnt_q[i] : acc_cnt_q[i] + 1'b1;
			change[i]  = (acc_inc[i] >= debounce_q) && (raw_pressed[i] != state_q[i]);
			next_st[i] = change[i] ? raw_pressed[i] : state_q[i];
		end
		snap_inc  = (snap_cnt_q == SNAP_MAX) ? snap_cnt_q : snap_cnt_q + 1'b1;
		interval  = (snap_int_q == '0) ? SNAP_W'(1) : snap_int_q;
		rise      = link_in && !link_was_q;
		post_snap = link_in && !rise && (snap_inc >= interval);
		ev_mask   = link_in ? change : '0;
	end

	always_comb begin
		ev_idx = '0;
		for (int i = BUTTONS - 1; i >= 0; i--) begin
			if (ev_mask_q[i]) begin
				ev_idx = IDX_W'(i);
			end
		end
		ev_rest = ev_mask_q & ~(BUTTONS'(1) << ev_idx);
	end

	always_comb begin
		if (pre_q) begin
			emit_idx  = idx_q;
			emit_st   = old_st_q[idx_q];
			emit_snap = 1'b1;
			last_item = (idx_q == IDX_LAST) && (ev_mask_q == '0) && !post_q;
		end else if (ev_mask_q != '0) begin
			emit_idx  = ev_idx;
			emit_st   = new_st_q[ev_idx];
			emit_snap = 1'b0;
			last_item = (ev_rest == '0) && !post_q;
		end else begin
			emit_idx  = idx_q;
			emit_st   = new_st_q[idx_q];
			emit_snap = 1'b1;
			last_item = (idx_q == IDX_LAST);
		end
		emit_chan = CHAN_W'(emit_idx / BUTTONS_PER_GROUP);
		emit_bnum = BNUM_W'(emit_idx % BUTTONS_PER_GROUP) + 1'b1;
	end

	assign step     = busy && (!m_tvalid || m_tready);
	assign s_tready = !busy || (step && last_item);
	assign busy     = pre_q || post_q || (ev_mask_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEB_RESET;
			snap_int_q <= SNAP_RESET;
			seq_q      <= '0;
			state_q    <= '0;
			for (int i = 0; i < BUTTONS; i++) begin
				acc_cnt_q[i] <= '0;
			end
			snap_cnt_q <= '0;
			link_was_q <= 1'b0;
			pre_q      <= 1'b0;
			post_q     <= 1'b0;
			ev_mask_q  <= '0;
			idx_q      <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE: debounce_q <= cfg_data[DEB_W-1:0];
					REG_SNAPSHOT: snap_int_q <= cfg_data[SNAP_W-1:0];
					REG_SEQSTART: seq_q      <= cfg_data;
					default: ;
				endcase
			end

			// advance the job by one result
			if (step) begin
				seq_q <= seq_q + 1'b1;
				if (pre_q) begin
					if (idx_q == IDX_LAST) begin
						pre_q <= 1'b0;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end else if (ev_mask_q != '0) begin
					ev_mask_q <= ev_rest;
				end else begin
					if (idx_q == IDX_LAST) begin
						post_q <= 1'b0;
						idx_q  <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end

			if (in_fire) begin
				state_q <= next_st;
				for (int i = 0; i < BUTTONS; i++) begin
					acc_cnt_q[i] <= change[i] ? '0 : acc_inc[i];
				end
				snap_cnt_q <= (rise || post_snap) ? '0 : snap_inc;
				link_was_q <= link_in;
				pre_q      <= rise;
				post_q     <= post_snap;
				ev_mask_q  <= ev_mask;
				idx_q      <= '0;
			end

			if (step) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			old_st_q <= state_q;
			new_st_q <= next_st;
		end
		if (step) begin
			m_tdata <= {2'b00, seq_q + 1'b1, emit_st, emit_bnum, emit_chan};
			m_tuser <= emit_snap;
			m_tlast <= last_item;
		end
	end

	a_seq_matches : assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (m_tvalid && m_tdata[37:6] == seq_q))
		else $error("result sequence number out of step with counter");

	a_tick_overlap : assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && busy) |-> (step && last_item))
		else $error("tick accepted while a job still has results");

	a_snap_exclusive : assert property (@(posedge clk) disable iff (!arst_n)
		!(pre_q && post_q))
		else $error("both snapshots pending in one tick");

endmodule
`default_nettype wire
